[design/pit_pkg.sv]
// Shared types and constants for the pending interest table.
package pit_pkg;

   localparam int unsigned NUM_FACES = 32;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RTT_TICKS          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGGREGATION_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOPS_TRANSPARENT   = 2'd2;

   localparam logic [30:0] RTT_TICKS_RESET = 31'd1000;

   typedef enum logic [2:0] {
      ACT_DROP        = 3'd0,
      ACT_CACHE       = 3'd1,
      ACT_REPO        = 3'd2,
      ACT_FORWARD     = 3'd3,
      ACT_AGGREGATE   = 3'd4,
      ACT_FANOUT      = 3'd5,
      ACT_UNSOLICITED = 3'd6
   } action_type;

   typedef struct packed {
      logic [30:0] rtt_ticks;
      logic        aggregation_enable;
      logic        hops_transparent;
   } cfg_type;

   typedef struct packed {
      logic        mode;
      logic [63:0] chunk_key;
      logic [4:0]  arrival_face;
      logic [31:0] now_time;
      logic [7:0]  hops_in;
      logic [7:0]  ttl_limit;
      logic        cache_hit;
      logic        repo_hit;
      logic        not_found_flag;
      logic        aggregate_flag;
      logic        target_is_self;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  hops_out;
      logic [31:0] face_mask;
      logic        table_full;
   } rsp_type;

   // lookup result of the table for the key in the work stage
   typedef struct packed {
      logic        hit;
      logic        free_found;
      logic [31:0] time_val;
      logic [31:0] faces;
   } tbl_lookup_type;

   // table write for the current transaction
   typedef struct packed {
      logic        clr_hit;
      logic        wr_hit;
      logic        wr_free;
      logic        set_time;
      logic [63:0] key;
      logic [31:0] time_val;
      logic [31:0] faces;
   } tbl_update_type;

endpackage

[design/pit_csr.sv]
// Configuration registers of the pending interest table.
module pit_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pit_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata,
   output pit_pkg::cfg_type               cfg
);
   import pit_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RTT_TICKS:          cfg_in.rtt_ticks = csr_wdata[30:0];
            CSR_AGGREGATION_ENABLE: cfg_in.aggregation_enable = csr_wdata[0];
            CSR_HOPS_TRANSPARENT:   cfg_in.hops_transparent = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rtt_ticks          <= RTT_TICKS_RESET;
         cfg_ff.aggregation_enable <= 1'b1;
         cfg_ff.hops_transparent   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/pit_table.sv]
// Entry storage with parallel key match, free-slot search and update.
module pit_table #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [63:0]              lookup_key,
   output pit_pkg::tbl_lookup_type  lookup,
   input  pit_pkg::tbl_update_type  update
);
   import pit_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [63:0]              key_ff   [TABLE_ENTRIES];
   logic [31:0]              time_ff  [TABLE_ENTRIES];
   logic [31:0]              faces_ff [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [TABLE_ENTRIES-1:0] free_vec;

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == lookup_key);
      end
   end

   // lowest clear bit of the valid vector
   assign free_vec = ~valid_ff & (valid_ff + TABLE_ENTRIES'(1));

   // keys are unique among valid entries, so at most one entry matches
   always_comb begin
      lookup.hit        = |hit_vec;
      lookup.free_found = |free_vec;
      lookup.time_val   = '0;
      lookup.faces      = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         lookup.time_val = lookup.time_val | (time_ff[i] & {32{hit_vec[i]}});
         lookup.faces    = lookup.faces | (faces_ff[i] & {32{hit_vec[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (update.clr_hit && hit_vec[i]) begin
               valid_ff[i] <= 1'b0;
            end else if ((update.wr_hit && hit_vec[i]) || (update.wr_free && free_vec[i])) begin
               valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if ((update.wr_hit && hit_vec[i]) || (update.wr_free && free_vec[i])) begin
            key_ff[i]   <= update.key;
            faces_ff[i] <= update.faces;
            if (update.set_time) begin
               time_ff[i] <= update.time_val;
            end
         end
      end
   end

   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("pit_table: key matches more than one entry");

   a_alloc_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      update.wr_free |-> !lookup.hit && lookup.free_found)
      else $error("pit_table: allocation while key present or table full");

endmodule

[design/pit_decide.sv]
// Per-packet decision: hop update, action select and table write.
module pit_decide (
   input  logic                     work_valid,
   input  pit_pkg::req_type         req,
   input  pit_pkg::cfg_type         cfg,
   input  pit_pkg::tbl_lookup_type  lookup,
   output pit_pkg::tbl_update_type  update,
   output pit_pkg::rsp_type         rsp
);
   import pit_pkg::*;

   logic [7:0]  hops_nx;
   logic [31:0] age;
   logic        stale;
   logic        refresh;
   logic [31:0] face_bit;

   assign hops_nx = (!cfg.hops_transparent && req.hops_in != 8'hFF) ?
                    req.hops_in + 8'd1 : req.hops_in;

   assign age     = req.now_time - lookup.time_val;
   assign stale   = age > {cfg.rtt_ticks, 1'b0};
   assign refresh = !lookup.hit || req.not_found_flag || stale;

   assign face_bit = ({2'b00, req.arrival_face} < 7'(NUM_FACES)) ?
                     (32'd1 << req.arrival_face) : 32'd0;

   always_comb begin
      update          = '0;
      update.key      = req.chunk_key;
      update.time_val = req.now_time;
      rsp.action      = ACT_UNSOLICITED;
      rsp.hops_out    = hops_nx;
      rsp.face_mask   = '0;
      rsp.table_full  = 1'b0;
      priority if (req.mode) begin
         if (lookup.hit) begin
            rsp.action     = ACT_FANOUT;
            rsp.face_mask  = lookup.faces;
            update.clr_hit = work_valid;
         end
      end else if (hops_nx == req.ttl_limit) begin
         rsp.action = ACT_DROP;
      end else if (req.cache_hit) begin
         rsp.action = ACT_CACHE;
      end else if (req.repo_hit) begin
         rsp.action = ACT_REPO;
      end else begin
         if (lookup.hit) begin
            update.wr_hit   = work_valid;
            update.set_time = refresh;
            update.faces    = (refresh ? 32'd0 : lookup.faces) | face_bit;
         end else if (lookup.free_found) begin
            update.wr_free  = work_valid;
            update.set_time = 1'b1;
            update.faces    = face_bit;
         end else begin
            rsp.table_full = 1'b1;
         end
         if (refresh || !cfg.aggregation_enable || !req.aggregate_flag ||
             req.target_is_self) begin
            rsp.action = ACT_FORWARD;
         end else begin
            rsp.action = ACT_AGGREGATE;
         end
      end
   end

endmodule

[design/pending_interest_table.sv]
// Top level of the pending interest table.
//
// Input: a packet header is taken at a rising edge where start is high and
// busy is low. busy is never raised, so one packet may be issued per cycle.
// Output: each packet yields exactly one result, shown on the rsp_ ports for
// one cycle while rsp_valid is high, after the input and result registers.
// The receiver cannot stall, so results are never held back.
// Pipeline: input register, then lookup/decide/update into the result
// register. Throughput: one packet per cycle; the table's key match,
// face merge and write all settle between the input register and the
// result register, so the next packet sees the updated table.
// Configuration: csr_valid/csr_ready write channel, index 0 rtt_ticks,
// 1 aggregation_enable, 2 hops_transparent; writes to other indexes are
// dropped. Write only while no packet is in flight.
// Reset (synchronous, active high) empties the table and loads register
// defaults: rtt_ticks 1000, aggregation on, hop counting on. The table is
// usable in the first cycle after reset.
module pending_interest_table #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [63:0]                    req_chunk_key,
   input  logic [4:0]                     req_arrival_face,
   input  logic [31:0]                    req_now_time,
   input  logic [7:0]                     req_hops_in,
   input  logic [7:0]                     req_ttl_limit,
   input  logic                           req_cache_hit,
   input  logic                           req_repo_hit,
   input  logic                           req_not_found_flag,
   input  logic                           req_aggregate_flag,
   input  logic                           req_target_is_self,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_action,
   output logic [7:0]                     rsp_hops_out,
   output logic [31:0]                    rsp_face_mask,
   output logic                           rsp_table_full,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pit_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);
   import pit_pkg::*;

   logic           work_valid_ff;
   logic           work_valid_in;
   req_type        req_ff;
   req_type        req_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;

   cfg_type        cfg;
   tbl_lookup_type lookup;
   tbl_update_type update;
   logic           accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign work_valid_in = accept;
   always_comb begin
      req_in.mode           = req_mode;
      req_in.chunk_key      = req_chunk_key;
      req_in.arrival_face   = req_arrival_face;
      req_in.now_time       = req_now_time;
      req_in.hops_in        = req_hops_in;
      req_in.ttl_limit      = req_ttl_limit;
      req_in.cache_hit      = req_cache_hit;
      req_in.repo_hit       = req_repo_hit;
      req_in.not_found_flag = req_not_found_flag;
      req_in.aggregate_flag = req_aggregate_flag;
      req_in.target_is_self = req_target_is_self;
   end

   pit_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pit_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_key (req_ff.chunk_key),
      .lookup     (lookup),
      .update     (update)
   );

   pit_decide u_decide (
      .work_valid (work_valid_ff),
      .req        (req_ff),
      .cfg        (cfg),
      .lookup     (lookup),
      .update     (update),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= work_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_ff.action;
   assign rsp_hops_out   = rsp_ff.hops_out;
   assign rsp_face_mask  = rsp_ff.face_mask;
   assign rsp_table_full = rsp_ff.table_full;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("pit: accepted transaction gave no result two cycles later");

   a_full_forwards: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_ff.action == ACT_FORWARD)
      else $error("pit: table_full on a result that is not a forward");

   a_mask_only_fanout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_face_mask != 32'd0 |-> rsp_ff.action == ACT_FANOUT)
      else $error("pit: face mask on a result that is not a data fanout");

   a_no_update_idle: assert property (@(posedge clock) disable iff (reset)
      !work_valid_ff |-> !update.clr_hit && !update.wr_hit && !update.wr_free)
      else $error("pit: table written without a transaction in work");

endmodule

[test/tb_pending_interest_table.sv]
// Self-checking testbench for the pending interest table: directed and random packets.
`timescale 1ns / 1ps

module tb_pending_interest_table;
   import pit_pkg::*;

   localparam int unsigned TABLE_ENTRIES = 32;
   localparam int unsigned KEY_POOL_SIZE = 64;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned MAX_REPORTS   = 50;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // interest flag bits for directed packets
   localparam logic [4:0] F_CACHE = 5'b10000;
   localparam logic [4:0] F_REPO  = 5'b01000;
   localparam logic [4:0] F_NF    = 5'b00100;
   localparam logic [4:0] F_AGG   = 5'b00010;
   localparam logic [4:0] F_SELF  = 5'b00001;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_mode = 1'b0;
   logic [63:0]          req_chunk_key = '0;
   logic [4:0]           req_arrival_face = '0;
   logic [31:0]          req_now_time = '0;
   logic [7:0]           req_hops_in = '0;
   logic [7:0]           req_ttl_limit = '0;
   logic                 req_cache_hit = 1'b0;
   logic                 req_repo_hit = 1'b0;
   logic                 req_not_found_flag = 1'b0;
   logic                 req_aggregate_flag = 1'b0;
   logic                 req_target_is_self = 1'b0;
   logic                 rsp_valid;
   logic [2:0]           rsp_action;
   logic [7:0]           rsp_hops_out;
   logic [31:0]          rsp_face_mask;
   logic                 rsp_table_full;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   pending_interest_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_chunk_key      (req_chunk_key),
      .req_arrival_face   (req_arrival_face),
      .req_now_time       (req_now_time),
      .req_hops_in        (req_hops_in),
      .req_ttl_limit      (req_ttl_limit),
      .req_cache_hit      (req_cache_hit),
      .req_repo_hit       (req_repo_hit),
      .req_not_found_flag (req_not_found_flag),
      .req_aggregate_flag (req_aggregate_flag),
      .req_target_is_self (req_target_is_self),
      .rsp_valid          (rsp_valid),
      .rsp_action         (rsp_action),
      .rsp_hops_out       (rsp_hops_out),
      .rsp_face_mask      (rsp_face_mask),
      .rsp_table_full     (rsp_table_full),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the table and registers
   logic        tbl_valid [TABLE_ENTRIES];
   logic [63:0] tbl_key   [TABLE_ENTRIES];
   logic [31:0] tbl_time  [TABLE_ENTRIES];
   logic [31:0] tbl_faces [TABLE_ENTRIES];
   logic [30:0] cfg_rtt = RTT_TICKS_RESET;
   logic        cfg_agg = 1'b1;
   logic        cfg_transparent = 1'b0;

   req_type     packet_q [$];
   rsp_type     expected_rsp_q [$];
   req_type     drv_pkt;
   logic [63:0] key_pool [KEY_POOL_SIZE];
   logic [31:0] now_base = '0;
   int unsigned idle_pct = 6;
   int unsigned cycle_count = 0;
   int unsigned err_count = 0;
   int unsigned packets_sent = 0;
   int unsigned results_checked = 0;
   int unsigned full_seen = 0;
   int unsigned action_seen [8];

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i]   = '0;
         tbl_time[i]  = '0;
         tbl_faces[i] = '0;
      end
      for (int i = 0; i < 8; i++) action_seen[i] = 0;
   end

   function automatic rsp_type route_packet(req_type p);
      rsp_type     r;
      logic [7:0]  hops;
      logic [31:0] age;
      logic        refresh;
      int          slot;
      int          i;
      r = '0;
      hops = p.hops_in;
      if (!cfg_transparent && hops != 8'hFF) hops = hops + 8'd1;
      r.hops_out = hops;
      slot = -1;
      for (i = 0; i < TABLE_ENTRIES; i++)
         if (slot < 0 && tbl_valid[i] && tbl_key[i] == p.chunk_key) slot = i;

      if (p.mode) begin
         if (slot >= 0) begin
            r.action = ACT_FANOUT;
            r.face_mask = tbl_faces[slot];
            tbl_valid[slot] = 1'b0;
         end else begin
            r.action = ACT_UNSOLICITED;
         end
      end else if (hops == p.ttl_limit) begin
         r.action = ACT_DROP;
      end else if (p.cache_hit) begin
         r.action = ACT_CACHE;
      end else if (p.repo_hit) begin
         r.action = ACT_REPO;
      end else begin
         if (slot < 0) begin
            refresh = 1'b1;
         end else begin
            age = p.now_time - tbl_time[slot];
            refresh = p.not_found_flag || (age > {cfg_rtt, 1'b0});
         end
         if (refresh) begin
            if (slot < 0) begin
               // lowest free slot takes the new entry
               for (i = 0; i < TABLE_ENTRIES; i++)
                  if (slot < 0 && !tbl_valid[i]) slot = i;
               if (slot >= 0) begin
                  tbl_valid[slot] = 1'b1;
                  tbl_key[slot] = p.chunk_key;
               end
            end
            if (slot >= 0) begin
               tbl_faces[slot] = '0;
               tbl_time[slot] = p.now_time;
            end else begin
               r.table_full = 1'b1;
            end
         end
         if (slot >= 0 && p.arrival_face < NUM_FACES)
            tbl_faces[slot] = tbl_faces[slot] | (32'd1 << p.arrival_face);
         if (refresh || !cfg_agg || !p.aggregate_flag || p.target_is_self)
            r.action = ACT_FORWARD;
         else
            r.action = ACT_AGGREGATE;
      end
      return r;
   endfunction

   function automatic req_type make_pkt(logic mode, logic [63:0] key, logic [4:0] face,
                                        logic [31:0] now, logic [7:0] hops,
                                        logic [7:0] ttl, logic [4:0] flags);
      req_type p;
      p.mode           = mode;
      p.chunk_key      = key;
      p.arrival_face   = face;
      p.now_time       = now;
      p.hops_in        = hops;
      p.ttl_limit      = ttl;
      p.cache_hit      = flags[4];
      p.repo_hit       = flags[3];
      p.not_found_flag = flags[2];
      p.aggregate_flag = flags[1];
      p.target_is_self = flags[0];
      return p;
   endfunction

   task automatic queue_random(int unsigned count, int unsigned pool, int unsigned data_pct);
      req_type p;
      for (int n = 0; n < count; n++) begin
         p.mode = ($urandom_range(0, 99) < data_pct);
         if ($urandom_range(0, 99) < 8)
            p.chunk_key = {$urandom, $urandom};
         else
            p.chunk_key = key_pool[6'($urandom_range(0, pool - 1))];
         p.arrival_face = 5'($urandom_range(0, 31));
         case ($urandom_range(0, 99)) inside
            [0:1]:   now_base = $urandom;
            [2:6]:   now_base = now_base + $urandom_range(0, 5000);
            default: now_base = now_base + $urandom_range(0, 63);
         endcase
         p.now_time = now_base;
         p.hops_in = 8'($urandom_range(0, 255));
         // sometimes land exactly on the hop limit
         if ($urandom_range(0, 99) < 10)
            p.ttl_limit = p.hops_in + 8'($urandom_range(0, 1));
         else
            p.ttl_limit = 8'($urandom_range(0, 255));
         p.cache_hit      = ($urandom_range(0, 99) < 8);
         p.repo_hit       = ($urandom_range(0, 99) < 8);
         p.not_found_flag = ($urandom_range(0, 99) < 10);
         p.aggregate_flag = ($urandom_range(0, 99) < 75);
         p.target_is_self = ($urandom_range(0, 99) < 10);
         packet_q.push_back(p);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_RTT_TICKS:          cfg_rtt = data[30:0];
         CSR_AGGREGATION_ENABLE: cfg_agg = data[0];
         CSR_HOPS_TRANSPARENT:   cfg_transparent = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (packet_q.size() != 0 || start || expected_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver: one transaction per cycle unless idling
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp_q.push_back(route_packet(drv_pkt));
            packets_sent++;
         end
         if (!start || !busy) begin
            if (packet_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               drv_pkt = packet_q.pop_front();
               req_mode           <= drv_pkt.mode;
               req_chunk_key      <= drv_pkt.chunk_key;
               req_arrival_face   <= drv_pkt.arrival_face;
               req_now_time       <= drv_pkt.now_time;
               req_hops_in        <= drv_pkt.hops_in;
               req_ttl_limit      <= drv_pkt.ttl_limit;
               req_cache_hit      <= drv_pkt.cache_hit;
               req_repo_hit       <= drv_pkt.repo_hit;
               req_not_found_flag <= drv_pkt.not_found_flag;
               req_aggregate_flag <= drv_pkt.aggregate_flag;
               req_target_is_self <= drv_pkt.target_is_self;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
   endtask

   // monitor: results cannot be stalled, so take every strobe
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual action %0d",
                        $time, rsp_action);
         end else begin
            want = expected_rsp_q.pop_front();
            results_checked++;
            if (rsp_action !== want.action) report_mismatch("action", want.action, rsp_action);
            if (rsp_hops_out !== want.hops_out)
               report_mismatch("hops_out", want.hops_out, rsp_hops_out);
            if (rsp_face_mask !== want.face_mask)
               report_mismatch("face_mask", want.face_mask, rsp_face_mask);
            if (rsp_table_full !== want.table_full)
               report_mismatch("table_full", want.table_full, rsp_table_full);
         end
         action_seen[rsp_action]++;
         if (rsp_table_full === 1'b1) full_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_rsp_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [63:0] key_a;
      logic [63:0] key_b;
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      key_a = key_pool[0];
      key_b = key_pool[1];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed packets under the reset register values (2*rtt = 2000)
      packet_q.push_back(make_pkt(1'b1, key_a, 5'd3, 32'd100, 8'd0, 8'd0, 5'b0));
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd0, 32'd100, 8'd0, 8'd0, F_AGG));
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd31, 32'd110, 8'd1, 8'd0, F_AGG));
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd5, 32'd120, 8'd2, 8'd0, F_AGG | F_SELF));
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd6, 32'd130, 8'd3, 8'd0, 5'b0));
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd7, 32'd140, 8'd4, 8'd0, F_AGG | F_NF));
      // age exactly 2*rtt aggregates, one tick more refreshes
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd9, 32'd2140, 8'd5, 8'd0, F_AGG));
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd10, 32'd2141, 8'd6, 8'd0, F_AGG));
      packet_q.push_back(make_pkt(1'b0, key_a, 5'd20, 32'd2160, 8'd7, 8'd0, F_AGG));
      packet_q.push_back(make_pkt(1'b1, key_a, 5'd0, 32'd2200, 8'd7, 8'd8, F_CACHE));
      packet_q.push_back(make_pkt(1'b1, key_a, 5'd0, 32'd2210, 8'd7, 8'd8, 5'b0));
      packet_q.push_back(make_pkt(1'b0, key_b, 5'd1, 32'd3000, 8'd255, 8'd255, 5'b0));
      packet_q.push_back(make_pkt(1'b0, key_b, 5'd1, 32'd3000, 8'd4, 8'd5, 5'b0));
      packet_q.push_back(make_pkt(1'b0, key_b, 5'd1, 32'd3000, 8'd5, 8'd5, F_CACHE));
      packet_q.push_back(make_pkt(1'b0, key_b, 5'd1, 32'd3000, 8'd6, 8'd9, F_CACHE | F_REPO));
      packet_q.push_back(make_pkt(1'b0, key_b, 5'd1, 32'd3000, 8'd7, 8'd9, F_REPO | F_AGG));
      packet_q.push_back(make_pkt(1'b0, '1, 5'd31, 32'hFFFF_FFF0, 8'hFE, 8'h00,
                                  F_AGG | F_NF));
      packet_q.push_back(make_pkt(1'b0, '1, 5'd30, 32'h0000_0010, 8'h80, 8'hFF, F_AGG));
      packet_q.push_back(make_pkt(1'b1, '1, 5'd0, 32'h0000_0020, 8'hFE, 8'hFF,
                                  F_CACHE | F_REPO | F_NF | F_AGG | F_SELF));
      packet_q.push_back(make_pkt(1'b1, '0, 5'd0, 32'd0, 8'd255, 8'd0, 5'b0));
      packet_q.push_back(make_pkt(1'b0, '0, 5'd0, 32'd0, 8'd0, 8'd1, 5'b0));
      now_base = 32'd5000;
      queue_random(230, 40, 25);
      wait_drained();

      write_csr(CSR_RTT_TICKS, 32'h8000_0032);
      write_csr(CSR_AGGREGATION_ENABLE, $urandom & ~32'd1);
      write_csr(CSR_HOPS_TRANSPARENT, $urandom | 32'd1);
      queue_random(150, 24, 25);
      wait_drained();

      // no idling, wide key set, little data: fills the table
      idle_pct = 0;
      write_csr(CSR_RTT_TICKS, 32'd0);
      write_csr(CSR_AGGREGATION_ENABLE, 32'd1);
      write_csr(CSR_HOPS_TRANSPARENT, 32'd0);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      queue_random(150, 64, 3);
      wait_drained();

      idle_pct = 6;
      write_csr(CSR_RTT_TICKS, 32'hFFFF_FFFF);
      write_csr(CSR_HOPS_TRANSPARENT, 32'hFFFF_FFFF);
      queue_random(150, 32, 20);
      wait_drained();

      write_csr(CSR_RTT_TICKS, $urandom_range(100, 3000));
      write_csr(CSR_HOPS_TRANSPARENT, $urandom & ~32'd1);
      queue_random(200, 16, 30);
      wait_drained();

      $display("%0d packets sent, %0d results checked, %0d table-full responses",
               packets_sent, results_checked, full_seen);
      $display({"drop %0d, cache %0d, repo %0d, forward %0d, aggregate %0d, ",
                "fanout %0d, unsolicited %0d"},
               action_seen[ACT_DROP], action_seen[ACT_CACHE], action_seen[ACT_REPO],
               action_seen[ACT_FORWARD], action_seen[ACT_AGGREGATE],
               action_seen[ACT_FANOUT], action_seen[ACT_UNSOLICITED]);
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", err_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
design/pit_pkg.sv
design/pit_csr.sv
design/pit_table.sv
design/pit_decide.sv
design/pending_interest_table.sv
test/tb_pending_interest_table.sv
